FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the sequencer RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg
// Types, codes and constants of the character LCD nibble sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clns_pkg;

  // request actions
  typedef enum logic [2:0] {
    ACT_CMD  = 3'd0,
    ACT_DATA = 3'd1,
    ACT_INIT = 3'd2,
    ACT_HOME = 3'd3,
    ACT_GOTO = 3'd4
  } action_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COMMAND_WAIT = 3'd0,
    REG_HOME_EXTRA   = 3'd1,
    REG_POWER_UP     = 3'd2,
    REG_FUNCTION_SET = 3'd3,
    REG_ENTRY_MODE   = 3'd4,
    REG_DISPLAY_ON   = 3'd5
  } cfg_reg_e;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // register reset values
  localparam logic [15:0] COMMAND_WAIT_RST = 16'd50;
  localparam logic [15:0] HOME_EXTRA_RST   = 16'd2000;
  localparam logic [15:0] POWER_UP_RST     = 16'd15000;
  localparam logic [7:0]  FUNCTION_SET_RST = 8'd40;
  localparam logic [7:0]  ENTRY_MODE_RST   = 8'd6;
  localparam logic [7:0]  DISPLAY_ON_RST   = 8'd12;

  // fixed LCD commands and init timing
  localparam logic [7:0]  CMD_HOME        = 8'h02;
  localparam logic [7:0]  CMD_CLEAR       = 8'h01;
  localparam logic [7:0]  CMD_DISPLAY_OFF = 8'h08;
  localparam logic [7:0]  CMD_SET_ADDRESS = 8'h80;
  localparam logic [3:0]  NIBBLE_8BIT     = 4'h3;
  localparam logic [3:0]  NIBBLE_4BIT     = 4'h2;
  localparam logic [16:0] WAIT_8BIT_US    = 17'd5000;
  localparam logic [16:0] WAIT_4BIT_US    = 17'd1000;

  // step sequencing
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd1;
  localparam logic [STEP_W-1:0] INIT_POWER_STEP = 4'd0;
  localparam logic [STEP_W-1:0] INIT_8BIT_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] INIT_8BIT_LAST  = 4'd3;
  localparam logic [STEP_W-1:0] INIT_4BIT_STEP  = 4'd4;
  localparam logic [STEP_W-1:0] INIT_BYTE_FIRST = 4'd5;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd14;

  // init byte slots
  localparam logic [2:0] SLOT_FUNCTION_SET = 3'd0;
  localparam logic [2:0] SLOT_DISPLAY_OFF  = 3'd1;
  localparam logic [2:0] SLOT_CLEAR        = 3'd2;
  localparam logic [2:0] SLOT_ENTRY_MODE   = 3'd3;
  localparam logic [2:0] SLOT_DISPLAY_ON   = 3'd4;

  // channel payloads
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       row;
  } req_t;

  typedef struct packed {
    logic        pulse_enable;
    logic        register_select;
    logic [3:0]  nibble;
    logic [16:0] wait_after_us;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              load;
    logic              busy;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

FILE: rtl/clns_stream_if.sv
// ----------------------------------------------------------------------------
// clns_stream_if
// Valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface clns_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/clns_ctrl.sv
// ----------------------------------------------------------------------------
// clns_ctrl
// Sequencer controller: step counter, request and result handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clns_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic [2:0]             req_action_i,
  output logic                   req_ready_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  input  clns_pkg::dp_status_t   status_i,
  output clns_pkg::ctrl_cmd_t    cmd_o
);

  clns_pkg::state_e                  state_q, state_d;
  logic [clns_pkg::STEP_W-1:0]       step_q, step_d;
  logic                              out_valid_q, out_valid_d;
  logic                              accept;
  logic                              known_action;
  logic                              load;

  // state, step and output slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clns_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    accept       = 1'b0;
    load         = 1'b0;
    state_d      = state_q;
    step_d       = step_q;
    known_action = (req_action_i inside {clns_pkg::ACT_CMD, clns_pkg::ACT_DATA,
                                         clns_pkg::ACT_INIT, clns_pkg::ACT_HOME,
                                         clns_pkg::ACT_GOTO});
    case (state_q)
      clns_pkg::ST_IDLE: begin
        accept = req_valid_i;
        if (accept && known_action) begin
          state_d = clns_pkg::ST_RUN;
          step_d  = '0;
        end
      end
      clns_pkg::ST_RUN: begin
        load = !out_valid_q || res_ready_i;
        if (load) begin
          if (status_i.last) begin
            state_d = clns_pkg::ST_IDLE;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = clns_pkg::ST_IDLE;
      end
    endcase

    // output slot fills on load, empties when taken
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign req_ready_o   = (state_q == clns_pkg::ST_IDLE);
  assign res_valid_o   = out_valid_q;
  assign cmd_o.capture = accept;
  assign cmd_o.load    = load;
  assign cmd_o.busy    = (state_q == clns_pkg::ST_RUN);
  assign cmd_o.step    = step_q;

endmodule

FILE: rtl/clns_dp.sv
// ----------------------------------------------------------------------------
// clns_dp
// Sequencer datapath: config registers, request capture, result build
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clns_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clns_pkg::ctrl_cmd_t   cmd_i,
  input  clns_pkg::req_t        req_data_i,
  input  logic                  cfg_we_i,
  input  clns_pkg::cfg_t        cfg_data_i,
  output clns_pkg::res_t        res_data_o,
  output clns_pkg::dp_status_t  status_o
);

  logic [15:0]    command_wait_q;
  logic [15:0]    home_extra_q;
  logic [15:0]    power_up_q;
  logic [7:0]     function_set_q;
  logic [7:0]     entry_mode_q;
  logic [7:0]     display_on_q;
  clns_pkg::req_t req_q;
  clns_pkg::res_t res_q;
  clns_pkg::res_t res_d;

  logic [clns_pkg::STEP_W-1:0] step;
  logic [clns_pkg::STEP_W-1:0] init_ofs;
  logic [7:0]                  byte_sel;
  logic                        half;
  logic [16:0]                 byte_wait;
  logic [6:0]                  address;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_wait_q <= clns_pkg::COMMAND_WAIT_RST;
      home_extra_q   <= clns_pkg::HOME_EXTRA_RST;
      power_up_q     <= clns_pkg::POWER_UP_RST;
      function_set_q <= clns_pkg::FUNCTION_SET_RST;
      entry_mode_q   <= clns_pkg::ENTRY_MODE_RST;
      display_on_q   <= clns_pkg::DISPLAY_ON_RST;
    end else if (cfg_we_i) begin
      case (cfg_data_i.index)
        clns_pkg::REG_COMMAND_WAIT: command_wait_q <= cfg_data_i.value;
        clns_pkg::REG_HOME_EXTRA:   home_extra_q   <= cfg_data_i.value;
        clns_pkg::REG_POWER_UP:     power_up_q     <= cfg_data_i.value;
        clns_pkg::REG_FUNCTION_SET: function_set_q <= cfg_data_i.value[7:0];
        clns_pkg::REG_ENTRY_MODE:   entry_mode_q   <= cfg_data_i.value[7:0];
        clns_pkg::REG_DISPLAY_ON:   display_on_q   <= cfg_data_i.value[7:0];
        default: begin
        end
      endcase
    end
  end

  // request capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_data_i;
    end
    if (cmd_i.load) begin
      res_q <= res_d;
    end
  end

  // result for the current step
  always_comb begin
    step      = cmd_i.step;
    init_ofs  = step - clns_pkg::INIT_BYTE_FIRST;
    address   = 7'(req_q.column) + {req_q.row, 6'd0};
    byte_wait = {1'b0, command_wait_q};
    half      = step[0];
    byte_sel  = req_q.byte_value;

    case (req_q.action)
      clns_pkg::ACT_HOME: begin
        byte_sel  = clns_pkg::CMD_HOME;
        byte_wait = {1'b0, command_wait_q} + {1'b0, home_extra_q};
      end
      clns_pkg::ACT_GOTO: begin
        byte_sel = clns_pkg::CMD_SET_ADDRESS | {1'b0, address};
      end
      clns_pkg::ACT_INIT: begin
        half = init_ofs[0];
        case (init_ofs[3:1])
          clns_pkg::SLOT_FUNCTION_SET: byte_sel = function_set_q;
          clns_pkg::SLOT_DISPLAY_OFF:  byte_sel = clns_pkg::CMD_DISPLAY_OFF;
          clns_pkg::SLOT_CLEAR:        byte_sel = clns_pkg::CMD_CLEAR;
          clns_pkg::SLOT_ENTRY_MODE:   byte_sel = entry_mode_q;
          clns_pkg::SLOT_DISPLAY_ON:   byte_sel = display_on_q;
          default:                     byte_sel = display_on_q;
        endcase
      end
      default: begin
      end
    endcase

    // byte halves, high nibble first
    res_d.pulse_enable    = 1'b1;
    res_d.register_select = (req_q.action == clns_pkg::ACT_DATA);
    res_d.nibble          = half ? byte_sel[3:0] : byte_sel[7:4];
    res_d.wait_after_us   = half ? byte_wait : 17'd0;
    res_d.last            = (step == clns_pkg::BYTE_LAST_STEP);

    // fixed init pulses ahead of the init bytes
    if (req_q.action == clns_pkg::ACT_INIT) begin
      res_d.last = (step == clns_pkg::INIT_LAST_STEP);
      if (step == clns_pkg::INIT_POWER_STEP) begin
        res_d.pulse_enable  = 1'b0;
        res_d.nibble        = 4'd0;
        res_d.wait_after_us = {1'b0, power_up_q};
      end else if (step inside {[clns_pkg::INIT_8BIT_FIRST:clns_pkg::INIT_8BIT_LAST]}) begin
        res_d.nibble        = clns_pkg::NIBBLE_8BIT;
        res_d.wait_after_us = clns_pkg::WAIT_8BIT_US;
      end else if (step == clns_pkg::INIT_4BIT_STEP) begin
        res_d.nibble        = clns_pkg::NIBBLE_4BIT;
        res_d.wait_after_us = clns_pkg::WAIT_4BIT_US;
      end
    end
  end

  assign status_o.last = res_d.last;
  assign res_data_o    = res_q;

endmodule

FILE: rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Character LCD 4-bit bus sequencer: requests in, enable pulses and waits out
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  req_i    in   action, byte_value, column, row                 valid/ready
//  res_o    out  pulse_enable, register_select, nibble,          valid/ready
//                wait_after_us, last
//  cfg_i    in   index, value                                    valid/ready
//
//  a request of n results is accepted while idle, then the step counter gives
//  one result per step (2 for a byte, 15 for initialise)
//  a request with an unknown action is taken and gives nothing
//  rst_ni is asynchronous, active low; config registers reset to defaults
//  a stalled result holds in the output register; the counter waits on it
//  a new request is taken once the last result sits in the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_lcd_nibble_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  clns_stream_if.sink   req_i,
  clns_stream_if.source res_o,
  clns_stream_if.sink   cfg_i
);

  clns_pkg::ctrl_cmd_t  cmd;
  clns_pkg::dp_status_t status;

  logic start_req;
  logic last_load;
  logic step_ok;

  // controller
  clns_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.data.action),
    .req_ready_o  (req_i.ready),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // datapath
  clns_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_data_i (req_i.data),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .res_data_o (res_o.data),
    .status_o   (status)
  );

  // config writes always taken
  assign cfg_i.ready = 1'b1;

  // check terms
  assign start_req = req_i.valid && req_i.ready && (req_i.data.action <= clns_pkg::ACT_GOTO);
  assign last_load = cmd.load && status.last;
  assign step_ok   = (cmd.step <= clns_pkg::INIT_LAST_STEP);

  // checks
  `ASSERT_NEXT(a_known_req_starts, clk_i, rst_ni, start_req, cmd.busy, "request not started")
  `ASSERT_NEXT(a_last_ends, clk_i, rst_ni, last_load, !cmd.busy && res_o.valid, "run did not end")
  `ASSERT_ALWAYS(a_step_bound, clk_i, rst_ni, step_ok, "step counter out of range")
  `ASSERT_ALWAYS(a_load_only_busy, clk_i, rst_ni, !cmd.load || cmd.busy, "load while idle")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character LCD nibble sequencer
// ----------------------------------------------------------------------------
// Requests go in through a queue-fed driver. A monitor predicts the pulse
// sequence of every accepted request from its own copy of the registers and
// checks each result in order. Runs through reset, all-ones, all-zeros and
// random register settings. Both sides idle at random but in the last phase,
// and one long receiver hold-off backs the block up into its request input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import clns_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 90;

  // codes outside the defined actions and register indexes
  localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] ACT_MID_UNUSED   = 3'd6;
  localparam logic [2:0] ACT_LAST_CODE    = 3'd7;
  localparam logic [2:0] REG_UNUSED_LO    = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI    = 3'd7;

  localparam logic [6:0] ROW_OFFSET  = 7'h40;
  localparam int unsigned COL_SHOWN  = 39;
  localparam int unsigned COL_TOP    = 63;

  logic clk_i;
  logic rst_ni = 1'b0;

  clns_stream_if #(.payload_t(req_t)) req_if ();
  clns_stream_if #(.payload_t(res_t)) res_if ();
  clns_stream_if #(.payload_t(cfg_t)) cfg_if ();

  char_lcd_nibble_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  req_t request_q[$];
  res_t pulse_expect_q[$];
  res_t want_pulse;

  // register mirror
  logic [15:0] cmd_wait_m;
  logic [15:0] home_extra_m;
  logic [15:0] power_up_m;
  logic [7:0]  fn_set_m;
  logic [7:0]  entry_mode_m;
  logic [7:0]  disp_on_m;

  int unsigned tx_idle_pct = 28;
  int unsigned rx_idle_pct = 47;
  int unsigned req_taken;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  function automatic void add_pulse(ref res_t seq[$], input logic en, input logic rs,
                                    input logic [3:0] nib, input logic [16:0] wt);
    res_t p;
    p.pulse_enable    = en;
    p.register_select = rs;
    p.nibble          = nib;
    p.wait_after_us   = wt;
    p.last            = 1'b0;
    seq.push_back(p);
  endfunction

  // a byte goes out high nibble first, the wait rides on the low nibble
  function automatic void add_byte(ref res_t seq[$], input logic rs, input logic [7:0] b,
                                   input logic [16:0] wt);
    add_pulse(seq, 1'b1, rs, b[7:4], '0);
    add_pulse(seq, 1'b1, rs, b[3:0], wt);
  endfunction

  // expected pulse sequence of one request, appended to the expectation queue
  function automatic void predict_pulses(req_t rq);
    res_t        seq[$];
    logic [16:0] cmd_wait;
    logic [6:0]  ddram;
    cmd_wait = {1'b0, cmd_wait_m};
    ddram    = {1'b0, rq.column} + (rq.row ? ROW_OFFSET : 7'd0);
    case (rq.action)
      ACT_CMD:  add_byte(seq, 1'b0, rq.byte_value, cmd_wait);
      ACT_DATA: add_byte(seq, 1'b1, rq.byte_value, cmd_wait);
      ACT_INIT: begin
        add_pulse(seq, 1'b0, 1'b0, 4'h0, {1'b0, power_up_m});
        for (int i = 0; i < 3; i++) add_pulse(seq, 1'b1, 1'b0, NIBBLE_8BIT, WAIT_8BIT_US);
        add_pulse(seq, 1'b1, 1'b0, NIBBLE_4BIT, WAIT_4BIT_US);
        add_byte(seq, 1'b0, fn_set_m, cmd_wait);
        add_byte(seq, 1'b0, CMD_DISPLAY_OFF, cmd_wait);
        add_byte(seq, 1'b0, CMD_CLEAR, cmd_wait);
        add_byte(seq, 1'b0, entry_mode_m, cmd_wait);
        add_byte(seq, 1'b0, disp_on_m, cmd_wait);
      end
      ACT_HOME: add_byte(seq, 1'b0, CMD_HOME, cmd_wait + {1'b0, home_extra_m});
      ACT_GOTO: add_byte(seq, 1'b0, CMD_SET_ADDRESS | {1'b0, ddram}, cmd_wait);
      default: ;
    endcase
    if (seq.size() != 0) seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i]) pulse_expect_q.push_back(seq[i]);
  endfunction

  function automatic req_t make_req(logic [2:0] act, logic [7:0] b, logic [5:0] col,
                                    logic rw);
    req_t rq;
    rq.action     = act;
    rq.byte_value = b;
    rq.column     = col;
    rq.row        = rw;
    return rq;
  endfunction

  function automatic req_t rand_request();
    int unsigned pick;
    logic [2:0]  act;
    logic [5:0]  col;
    pick = $urandom_range(0, 99);
    col  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(COL_SHOWN + 1, COL_TOP))
                                       : 6'($urandom_range(0, COL_SHOWN));
    if (pick < 25)      act = ACT_CMD;
    else if (pick < 55) act = ACT_DATA;
    else if (pick < 63) act = ACT_INIT;
    else if (pick < 73) act = ACT_HOME;
    else if (pick < 93) act = ACT_GOTO;
    else                act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
    return make_req(act, 8'($urandom), col, 1'($urandom));
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data  <= request_q.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && req_taken >= HOLD_AT) begin
      res_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: register mirror, result check, prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_wait_m   <= COMMAND_WAIT_RST;
      home_extra_m <= HOME_EXTRA_RST;
      power_up_m   <= POWER_UP_RST;
      fn_set_m     <= FUNCTION_SET_RST;
      entry_mode_m <= ENTRY_MODE_RST;
      disp_on_m    <= DISPLAY_ON_RST;
      req_taken    <= 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          REG_COMMAND_WAIT: cmd_wait_m   <= cfg_if.data.value;
          REG_HOME_EXTRA:   home_extra_m <= cfg_if.data.value;
          REG_POWER_UP:     power_up_m   <= cfg_if.data.value;
          REG_FUNCTION_SET: fn_set_m     <= cfg_if.data.value[7:0];
          REG_ENTRY_MODE:   entry_mode_m <= cfg_if.data.value[7:0];
          REG_DISPLAY_ON:   disp_on_m    <= cfg_if.data.value[7:0];
          default: ;
        endcase
      end
      // check before predicting so a result never meets its own request
      if (res_if.valid && res_if.ready) begin
        if (pulse_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pulse, expected none, got %p", $time, res_if.data);
        end else begin
          want_pulse = pulse_expect_q.pop_front();
          if (res_if.data.pulse_enable !== want_pulse.pulse_enable ||
              res_if.data.register_select !== want_pulse.register_select ||
              res_if.data.nibble !== want_pulse.nibble ||
              res_if.data.wait_after_us !== want_pulse.wait_after_us ||
              res_if.data.last !== want_pulse.last) begin
            mismatches++;
            $display("%0t: pulse mismatch, expected en=%0b rs=%0b nib=%h wait=%0d last=%0b",
                     $time, want_pulse.pulse_enable, want_pulse.register_select,
                     want_pulse.nibble, want_pulse.wait_after_us, want_pulse.last);
            $display("%0t:                 actual   en=%0b rs=%0b nib=%h wait=%0d last=%0b",
                     $time, res_if.data.pulse_enable, res_if.data.register_select,
                     res_if.data.nibble, res_if.data.wait_after_us, res_if.data.last);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        predict_pulses(req_if.data);
        req_taken <= req_taken + 1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {idx, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // every register to one fill value, or each to a random one
  task automatic load_regs(logic [15:0] fill, bit pick_random);
    for (int i = REG_COMMAND_WAIT; i <= REG_DISPLAY_ON; i++)
      write_reg(3'(i), pick_random ? 16'($urandom) : fill);
  endtask

  // wait for all requests taken and all pulses seen, then let the block settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || req_if.valid || pulse_expect_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // queue random requests, ignored actions not counted
  task automatic queue_random(int unsigned n);
    req_t        rq;
    int unsigned counted;
    counted = 0;
    while (counted < n) begin
      rq = rand_request();
      request_q.push_back(rq);
      if (rq.action <= ACT_GOTO) counted++;
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed requests on reset register values
    @(negedge clk_i);
    request_q.push_back(make_req(ACT_CMD, 8'h00, 6'd0, 1'b0));
    request_q.push_back(make_req(ACT_CMD, 8'hFF, 6'd63, 1'b1));
    request_q.push_back(make_req(ACT_DATA, 8'h00, 6'd0, 1'b0));
    request_q.push_back(make_req(ACT_DATA, 8'hFF, 6'd0, 1'b0));
    request_q.push_back(make_req(ACT_DATA, 8'h5A, 6'd21, 1'b1));
    request_q.push_back(make_req(ACT_DATA, 8'hA5, 6'd42, 1'b0));
    request_q.push_back(make_req(ACT_INIT, 8'h00, 6'd0, 1'b0));
    request_q.push_back(make_req(ACT_HOME, 8'hFF, 6'd63, 1'b1));
    request_q.push_back(make_req(ACT_GOTO, 8'h00, 6'd0, 1'b0));
    request_q.push_back(make_req(ACT_GOTO, 8'h00, 6'd39, 1'b0));
    request_q.push_back(make_req(ACT_GOTO, 8'h00, 6'd0, 1'b1));
    request_q.push_back(make_req(ACT_GOTO, 8'hFF, 6'd39, 1'b1));
    request_q.push_back(make_req(ACT_GOTO, 8'h00, 6'd63, 1'b0));
    request_q.push_back(make_req(ACT_GOTO, 8'h00, 6'd63, 1'b1));
    request_q.push_back(make_req(ACT_FIRST_UNUSED, 8'hFF, 6'd63, 1'b1));
    request_q.push_back(make_req(ACT_MID_UNUSED, 8'h00, 6'd0, 1'b0));
    request_q.push_back(make_req(ACT_LAST_CODE, 8'h3C, 6'd5, 1'b1));
    request_q.push_back(make_req(ACT_CMD, 8'h01, 6'd0, 1'b0));
    request_q.push_back(make_req(ACT_INIT, 8'hFF, 6'd63, 1'b1));
    request_q.push_back(make_req(ACT_HOME, 8'h00, 6'd0, 1'b0));
    wait_drained();

    // all ones, spare index written and ignored
    tx_idle_pct = 28;
    rx_idle_pct = 47;
    load_regs(16'hFFFF, 1'b0);
    write_reg(REG_UNUSED_LO, 16'($urandom));
    @(negedge clk_i);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // all zeros, sender and receiver idle rates swapped
    tx_idle_pct = 47;
    rx_idle_pct = 28;
    load_regs(16'h0000, 1'b0);
    write_reg(REG_UNUSED_HI, 16'($urandom));
    @(negedge clk_i);
    queue_random(PHASE_ITEMS);
    wait_drained();

    load_regs('0, 1'b1);
    @(negedge clk_i);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // random registers, no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_regs('0, 1'b1);
    @(negedge clk_i);
    queue_random(PHASE_ITEMS);
    wait_drained();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/clns_pkg.sv
rtl/clns_stream_if.sv
rtl/clns_ctrl.sv
rtl/clns_dp.sv
rtl/char_lcd_nibble_sequencer.sv
test/tb_top.sv
